[src/psched_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
// Used by the controller, the datapath, the top level and the checker.
package psched_pkg;

  localparam int TIME_W = 21;
  localparam int SUM_W  = 25;
  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int JOB_W  = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b000_0001,
    ST_SCAN   = 7'b000_0010,
    ST_FETCH  = 7'b000_0100,
    ST_CALC_A = 7'b000_1000,
    ST_CALC_B = 7'b001_0000,
    ST_CALC_C = 7'b010_0000,
    ST_EMIT   = 7'b100_0000
  } state_t;

  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
  } job_info_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan_start;
    logic scan;
    logic fetch;
    logic calc_a;
    logic calc_b;
    logic calc_c;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

[src/preemptive_priority_scheduler_core.sv]
// Preemptive priority scheduler: one job table, one time unit per tick item.
// Input channel (in_valid/in_stall): action selects load, tick or clear; a
// load takes arrival_time, burst_length and job_priority. Loads into a full
// table or with zero burst are dropped. Load, clear and unused action codes
// are accepted only while idle and produce no result.
// A tick scans the table one entry per cycle through a single table read
// port, then updates time, the remaining service and the totals in a short
// sequence. A tick keeps the block busy until its result is registered, and
// each tick gives exactly one result on the output channel (out_valid/out_stall),
// held in an output register.
// The next item is accepted while a result waits in that register; a tick
// only stalls at its last step if the previous result is still not taken.
// A stalled result holds its value until transferred.
// Synchronous reset (rst) empties the table, zeroes time and totals and
// drops any pending result. Depends on psched_pkg, psched_ctrl, psched_dp.
module preemptive_priority_scheduler_core import psched_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [ARR_W-1:0]  arrival_time,
  input  logic [BUR_W-1:0]  burst_length,
  input  logic [PRI_W-1:0]  job_priority,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [JOB_W-1:0]  ran_job,
  output logic              idle_tick,
  output logic              job_finished,
  output logic [TIME_W-1:0] finish_time,
  output logic [TIME_W-1:0] turnaround,
  output logic [TIME_W-1:0] waiting,
  output logic [TIME_W-1:0] time_now,
  output logic              all_done,
  output logic [SUM_W-1:0]  total_turnaround,
  output logic [SUM_W-1:0]  total_waiting
);

  cmd_t cmd;
  sts_t sts;

  psched_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  psched_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .arrival_time     (arrival_time),
    .burst_length     (burst_length),
    .job_priority     (job_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .ran_job          (ran_job),
    .idle_tick        (idle_tick),
    .job_finished     (job_finished),
    .finish_time      (finish_time),
    .turnaround       (turnaround),
    .waiting          (waiting),
    .time_now         (time_now),
    .all_done         (all_done),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting)
  );

endmodule

[src/psched_ctrl.sv]
// Sequencing FSM for the scheduler: accepts items and steps the datapath.
// Depends on psched_pkg (state_t, cmd_t, sts_t, action codes).
module psched_ctrl import psched_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = accept && (action == ACT_LOAD);
    cmd.clear      = accept && (action == ACT_CLEAR);
    cmd.scan_start = accept && (action == ACT_TICK);
    cmd.scan       = (state == ST_SCAN);
    cmd.fetch      = (state == ST_FETCH);
    cmd.calc_a     = (state == ST_CALC_A);
    cmd.calc_b     = (state == ST_CALC_B);
    cmd.calc_c     = (state == ST_CALC_C);
    cmd.emit       = (state == ST_EMIT) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept && (action == ACT_TICK)) state_next = ST_SCAN;
      ST_SCAN:   if (sts.scan_done) state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_CALC_A;
      ST_CALC_A: state_next = ST_CALC_B;
      ST_CALC_B: state_next = ST_CALC_C;
      ST_CALC_C: state_next = ST_EMIT;
      ST_EMIT:   if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/psched_dp.sv]
// Scheduler datapath: job tables, sequential selection scan, time and totals,
// and the output register. Depends on psched_pkg; driven by psched_ctrl.
module psched_dp import psched_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [ARR_W-1:0]  arrival_time,
  input  logic [BUR_W-1:0]  burst_length,
  input  logic [PRI_W-1:0]  job_priority,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [JOB_W-1:0]  ran_job,
  output logic              idle_tick,
  output logic              job_finished,
  output logic [TIME_W-1:0] finish_time,
  output logic [TIME_W-1:0] turnaround,
  output logic [TIME_W-1:0] waiting,
  output logic [TIME_W-1:0] time_now,
  output logic              all_done,
  output logic [SUM_W-1:0]  total_turnaround,
  output logic [SUM_W-1:0]  total_waiting
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  job_info_t        info_mem [MAX_JOBS];
  logic [BUR_W-1:0] rem_mem  [MAX_JOBS];

  logic [CNT_W-1:0]    loaded_count, finished_count, scan_idx;
  logic [TIME_W-1:0]   cur_time;
  logic [SUM_W-1:0]    sum_tat, sum_wt;
  logic [MAX_JOBS-1:0] done_vec;

  logic             cmp_valid, found, fin_flag;
  logic [IDX_W-1:0] cmp_idx, best_idx;
  logic [PRI_W-1:0] best_prio;
  logic [ARR_W-1:0] best_arr;
  logic [TIME_W-1:0] tat_r, wt_r;
  job_info_t        rd_info;
  logic [BUR_W-1:0] rd_rem;

  logic             load_ok, issue, rd_en, rem_we, eligible, better;
  logic [IDX_W-1:0] lc_idx, rd_addr, rem_addr;
  logic [BUR_W-1:0] rem_wdata;
  logic [TIME_W-1:0] time_inc, tat_calc, wt_calc, arr_ext, burst_ext;
  logic [SUM_W:0]   tat_sum_raw, wt_sum_raw;
  logic [SUM_W-1:0] tat_sum_sat, wt_sum_sat;

  assign load_ok  = cmd.load && (loaded_count < CNT_W'(MAX_JOBS)) && (burst_length != '0);
  assign lc_idx   = loaded_count[IDX_W-1:0];
  assign issue    = (scan_idx < loaded_count);
  assign rd_en    = cmd.fetch || (cmd.scan && issue);
  assign rd_addr  = cmd.fetch ? best_idx : scan_idx[IDX_W-1:0];
  assign rem_we   = load_ok || (cmd.calc_a && found);
  assign rem_addr = cmd.calc_a ? best_idx : lc_idx;
  assign rem_wdata = cmd.calc_a ? (rd_rem - 1'b1) : burst_length;

  assign sts.scan_done = !issue && !cmp_valid;
  assign sts.out_free  = !out_valid || !out_stall;

  // selection compare on the entry read last cycle; strict compares keep
  // the lowest load index on a full tie
  assign eligible = !done_vec[cmp_idx] && (TIME_W'(rd_info.arrival) <= cur_time);
  assign better   = !found || (rd_info.prio < best_prio) ||
                    ((rd_info.prio == best_prio) && (rd_info.arrival < best_arr));

  assign time_inc  = (cur_time == TIME_MAX) ? cur_time : cur_time + 1'b1;
  assign arr_ext   = TIME_W'(best_arr);
  assign burst_ext = TIME_W'(rd_info.burst);
  assign tat_calc  = (cur_time > arr_ext) ? cur_time - arr_ext : '0;
  assign wt_calc   = (tat_r > burst_ext) ? tat_r - burst_ext : '0;

  assign tat_sum_raw = {1'b0, sum_tat} + (SUM_W+1)'(tat_r);
  assign wt_sum_raw  = {1'b0, sum_wt} + (SUM_W+1)'(wt_r);
  assign tat_sum_sat = (tat_sum_raw > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : tat_sum_raw[SUM_W-1:0];
  assign wt_sum_sat  = (wt_sum_raw > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : wt_sum_raw[SUM_W-1:0];

  // job tables
  always_ff @(posedge clk) begin
    if (load_ok) begin
      info_mem[lc_idx] <= '{arrival: arrival_time, burst: burst_length, prio: job_priority};
    end
    if (rem_we) begin
      rem_mem[rem_addr] <= rem_wdata;
    end
    if (rd_en) begin
      rd_info <= info_mem[rd_addr];
      rd_rem  <= rem_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count   <= '0;
      finished_count <= '0;
      cur_time       <= '0;
      sum_tat        <= '0;
      sum_wt         <= '0;
      done_vec       <= '0;
      cmp_valid      <= 1'b0;
      found          <= 1'b0;
      fin_flag       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.clear) begin
        loaded_count   <= '0;
        finished_count <= '0;
        cur_time       <= '0;
        sum_tat        <= '0;
        sum_wt         <= '0;
        done_vec       <= '0;
      end
      if (load_ok) begin
        loaded_count     <= loaded_count + 1'b1;
        done_vec[lc_idx] <= 1'b0;
      end

      if (cmd.scan_start) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= issue;
        cmp_idx   <= scan_idx[IDX_W-1:0];
        if (issue) scan_idx <= scan_idx + 1'b1;
        if (cmp_valid && eligible && better) begin
          found     <= 1'b1;
          best_idx  <= cmp_idx;
          best_prio <= rd_info.prio;
          best_arr  <= rd_info.arrival;
        end
      end

      if (cmd.calc_a) begin
        cur_time <= time_inc;
        fin_flag <= found && (rd_rem <= BUR_W'(1));
        if (found && (rd_rem <= BUR_W'(1))) begin
          done_vec[best_idx] <= 1'b1;
          finished_count     <= finished_count + 1'b1;
        end
      end
      if (cmd.calc_b) begin
        tat_r <= fin_flag ? tat_calc : '0;
      end
      if (cmd.calc_c) begin
        wt_r <= fin_flag ? wt_calc : '0;
        if (fin_flag) sum_tat <= tat_sum_sat;
      end

      if (cmd.emit) begin
        if (fin_flag) sum_wt <= wt_sum_sat;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ran_job          <= found ? JOB_W'(best_idx) : '0;
      idle_tick        <= !found;
      job_finished     <= fin_flag;
      finish_time      <= fin_flag ? cur_time : '0;
      turnaround       <= tat_r;
      waiting          <= wt_r;
      time_now         <= cur_time;
      all_done         <= (finished_count >= loaded_count);
      total_turnaround <= sum_tat;
      total_waiting    <= fin_flag ? wt_sum_sat : sum_wt;
    end
  end

endmodule

[src/psched_chk.sv]
// Port-level checker for the scheduler top level, attached by bind.
// Depends on psched_pkg for the action codes and field widths.
module psched_chk import psched_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        action,
  input logic              out_valid,
  input logic              out_stall,
  input logic [JOB_W-1:0]  ran_job,
  input logic              idle_tick,
  input logic              job_finished,
  input logic [TIME_W-1:0] finish_time,
  input logic [TIME_W-1:0] turnaround,
  input logic [TIME_W-1:0] waiting,
  input logic [TIME_W-1:0] time_now
);

  // a tick keeps the block busy while it scans
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == ACT_TICK) |=> in_stall)
    else $error("tick transfer not followed by busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(time_now) && $stable(ran_job))
    else $error("stalled result changed");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle_tick |-> !job_finished && (ran_job == '0) && (finish_time == '0))
    else $error("idle tick reports a job");

  a_finish_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && job_finished |->
      (finish_time == time_now) && (turnaround <= finish_time) && (waiting < turnaround))
    else $error("finished job times inconsistent");

endmodule

bind preemptive_priority_scheduler_core psched_chk u_psched_chk (.*);

[sim/tb_preemptive_priority_scheduler_core.sv]
// Self-checking testbench for preemptive_priority_scheduler_core: directed and random
// load/tick/clear traffic, with random idling and backpressure on both channels.
// Depends on psched_pkg and the core; holds its own scheduler predictor.
module tb_preemptive_priority_scheduler_core;
  import psched_pkg::*;

  localparam int MAX_JOBS = 16;

  typedef struct packed {
    logic [JOB_W-1:0]  ran_job;
    logic              idle_tick;
    logic              job_finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] time_now;
    logic              all_done;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
  } tick_result_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        action = 2'd0;
  logic [ARR_W-1:0]  arrival_time = '0;
  logic [BUR_W-1:0]  burst_length = '0;
  logic [PRI_W-1:0]  job_priority = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [JOB_W-1:0]  ran_job;
  logic              idle_tick;
  logic              job_finished;
  logic [TIME_W-1:0] finish_time;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] waiting;
  logic [TIME_W-1:0] time_now;
  logic              all_done;
  logic [SUM_W-1:0]  total_turnaround;
  logic [SUM_W-1:0]  total_waiting;

  preemptive_priority_scheduler_core #(.MAX_JOBS(MAX_JOBS)) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .arrival_time     (arrival_time),
    .burst_length     (burst_length),
    .job_priority     (job_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .ran_job          (ran_job),
    .idle_tick        (idle_tick),
    .job_finished     (job_finished),
    .finish_time      (finish_time),
    .turnaround       (turnaround),
    .waiting          (waiting),
    .time_now         (time_now),
    .all_done         (all_done),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting)
  );

  // Scheduler predictor state
  logic [ARR_W-1:0]  tbl_arrival [MAX_JOBS];
  logic [BUR_W-1:0]  tbl_burst   [MAX_JOBS];
  logic [BUR_W-1:0]  tbl_left    [MAX_JOBS];
  logic [PRI_W-1:0]  tbl_prio    [MAX_JOBS];
  bit                tbl_done    [MAX_JOBS];
  int                n_loaded;
  int                n_finished;
  logic [TIME_W-1:0] sched_time;
  logic [SUM_W-1:0]  sum_tat;
  logic [SUM_W-1:0]  sum_wait;

  tick_result_t pending_ticks[$];

  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  int hold_off_left = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_completions = 0;
  int n_idle = 0;
  int n_dropped_loads = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, pending_ticks.size());
    $display("FAIL");
    $finish;
  end

  function automatic void clear_schedule();
    for (int i = 0; i < MAX_JOBS; i++) tbl_done[i] = 1'b0;
    n_loaded = 0;
    n_finished = 0;
    sched_time = '0;
    sum_tat = '0;
    sum_wait = '0;
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [TIME_W-1:0] inc);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(inc);
    return (s > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic tick_result_t predict_tick();
    tick_result_t r;
    bit found;
    int pick;
    r = '0;
    found = 1'b0;
    pick = 0;
    // lowest priority value, then earliest arrival, then lowest index
    for (int i = 0; i < n_loaded; i++) begin
      if (tbl_done[i] || TIME_W'(tbl_arrival[i]) > sched_time) continue;
      if (!found || tbl_prio[i] < tbl_prio[pick] ||
          (tbl_prio[i] == tbl_prio[pick] && tbl_arrival[i] < tbl_arrival[pick])) begin
        found = 1'b1;
        pick = i;
      end
    end
    if (sched_time != TIME_MAX) sched_time = sched_time + 1'b1;
    if (found) begin
      r.ran_job = pick[JOB_W-1:0];
      if (tbl_left[pick] != '0) tbl_left[pick] = tbl_left[pick] - 1'b1;
      if (tbl_left[pick] == '0) begin
        r.job_finished = 1'b1;
        r.finish_time = sched_time;
        r.turnaround = (sched_time > TIME_W'(tbl_arrival[pick])) ?
                       sched_time - TIME_W'(tbl_arrival[pick]) : '0;
        r.waiting = (r.turnaround > TIME_W'(tbl_burst[pick])) ?
                    r.turnaround - TIME_W'(tbl_burst[pick]) : '0;
        tbl_done[pick] = 1'b1;
        n_finished++;
        sum_tat = sat_sum(sum_tat, r.turnaround);
        sum_wait = sat_sum(sum_wait, r.waiting);
      end
    end else begin
      r.idle_tick = 1'b1;
    end
    r.time_now = sched_time;
    r.all_done = (n_finished >= n_loaded);
    r.total_turnaround = sum_tat;
    r.total_waiting = sum_wait;
    return r;
  endfunction

  // Advances the predictor by one accepted item; returns 1 when a result follows.
  function automatic bit apply_item(input action_t act, input logic [ARR_W-1:0] arr,
                                    input logic [BUR_W-1:0] bur, input logic [PRI_W-1:0] pri,
                                    output tick_result_t r);
    r = '0;
    case (act)
      ACT_LOAD: begin
        if (n_loaded < MAX_JOBS && bur != '0) begin
          tbl_arrival[n_loaded] = arr;
          tbl_burst[n_loaded] = bur;
          tbl_left[n_loaded] = bur;
          tbl_prio[n_loaded] = pri;
          tbl_done[n_loaded] = 1'b0;
          n_loaded++;
        end else begin
          n_dropped_loads++;
        end
      end
      ACT_CLEAR: clear_schedule();
      ACT_TICK: begin
        r = predict_tick();
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // True while some job could still run within a short horizon.
  function automatic bit work_left();
    for (int i = 0; i < n_loaded; i++)
      if (!tbl_done[i] && 32'(tbl_arrival[i]) <= 32'(sched_time) + 20) return 1'b1;
    return 1'b0;
  endfunction

  // Called at a rising edge; returns at the edge where the item transfers.
  task automatic send_item(action_t act, logic [ARR_W-1:0] arr, logic [BUR_W-1:0] bur,
                           logic [PRI_W-1:0] pri);
    tick_result_t r;
    if (gaps_on) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    action <= act;
    arrival_time <= arr;
    burst_length <= bur;
    job_priority <= pri;
    do @(posedge clk); while (in_stall);
    if (apply_item(act, arr, bur, pri, r)) pending_ticks.push_back(r);
    n_sent++;
  endtask

  // Drops valid, changes the idling mode and may set a receiver hold-off between edges.
  task automatic set_idling(bit on, int hold_cycles);
    in_valid <= 1'b0;
    @(negedge clk);
    gaps_on = on;
    stall_on = on;
    if (hold_cycles > 0) hold_off_left = hold_cycles;
    @(posedge clk);
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, ARR_W'($urandom), BUR_W'($urandom), PRI_W'($urandom));
  endtask

  task automatic send_random_load();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8)
      send_item(ACT_LOAD, ARR_W'($urandom), '0, PRI_W'($urandom));
    else if (roll < 13)
      send_item(ACT_LOAD, ARR_W'($urandom), BUR_W'($urandom), PRI_W'($urandom));
    else
      send_item(ACT_LOAD, sched_time[ARR_W-1:0] + ARR_W'($urandom_range(12)),
                BUR_W'($urandom_range(1, 6)), PRI_W'($urandom_range(7)));
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
      n_errors++;
    end
  endfunction

  // Result checker and receiver-side stall generator
  always @(posedge clk) begin
    tick_result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_ticks.size() == 0) begin
          $display("%0t: result transfer with no tick outstanding (time_now %0d)",
                   $time, time_now);
          n_errors++;
        end else begin
          e = pending_ticks.pop_front();
          n_checked++;
          if (e.job_finished) n_completions++;
          if (e.idle_tick) n_idle++;
          check_field("ran_job", 32'(e.ran_job), 32'(ran_job));
          check_field("idle_tick", 32'(e.idle_tick), 32'(idle_tick));
          check_field("job_finished", 32'(e.job_finished), 32'(job_finished));
          check_field("finish_time", 32'(e.finish_time), 32'(finish_time));
          check_field("turnaround", 32'(e.turnaround), 32'(turnaround));
          check_field("waiting", 32'(e.waiting), 32'(waiting));
          check_field("time_now", 32'(e.time_now), 32'(time_now));
          check_field("all_done", 32'(e.all_done), 32'(all_done));
          check_field("total_turnaround", 32'(e.total_turnaround), 32'(total_turnaround));
          check_field("total_waiting", 32'(e.total_waiting), 32'(total_waiting));
        end
      end
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= stall_on && ($urandom_range(99) < 8);
      end
    end
  end

  task automatic test_empty_table();
    send_tick();
    send_item(ACT_NONE, '1, '1, '1);
    send_tick();
    send_item(ACT_LOAD, '0, BUR_W'(1), '0);
    send_tick();
    // nothing left to run: idle with all_done set
    send_tick();
  endtask

  task automatic test_priority_order();
    send_item(ACT_CLEAR, '0, '0, '0);
    send_item(ACT_LOAD, ARR_W'(0), BUR_W'(3), PRI_W'(5));
    send_item(ACT_LOAD, ARR_W'(0), BUR_W'(2), PRI_W'(5));
    send_item(ACT_LOAD, ARR_W'(2), BUR_W'(1), PRI_W'(0));
    send_item(ACT_LOAD, ARR_W'(1), BUR_W'(1), PRI_W'(5));
    send_item(ACT_LOAD, '1, '0, '1);
    send_item(ACT_LOAD, '1, '1, '1);
    send_item(ACT_NONE, '1, '1, '1);
    send_item(ACT_LOAD, ARR_W'(0), BUR_W'(1), '1);
    // late high-priority arrival preempts; last tick idles on the far-future job
    repeat (9) send_tick();
    send_item(ACT_CLEAR, '1, '1, '1);
  endtask

  task automatic run_random_schedule();
    int n_jobs;
    int guard;
    if ($urandom_range(99) < 85)
      send_item(ACT_CLEAR, ARR_W'($urandom), BUR_W'($urandom), PRI_W'($urandom));
    n_jobs = $urandom_range(1, 18);
    for (int j = 0; j < n_jobs; j++) begin
      if ($urandom_range(99) < 5)
        send_item(ACT_NONE, ARR_W'($urandom), BUR_W'($urandom), PRI_W'($urandom));
      send_random_load();
    end
    guard = 0;
    while (work_left() && guard < 150) begin
      if ($urandom_range(99) < 6) send_random_load();
      else send_tick();
      guard++;
    end
    repeat ($urandom_range(3)) send_tick();
  endtask

  task automatic test_output_backpressure();
    set_idling(1'b0, 300);
    send_item(ACT_CLEAR, '0, '0, '0);
    send_item(ACT_LOAD, ARR_W'(0), BUR_W'(4), PRI_W'(3));
    send_item(ACT_LOAD, ARR_W'(1), BUR_W'(3), PRI_W'(1));
    send_item(ACT_LOAD, ARR_W'(0), BUR_W'(5), PRI_W'(3));
    // receiver is held off; the block fills and stalls the sender
    repeat (12) send_tick();
    set_idling(1'b1, 0);
  endtask

  task automatic test_steady_stream();
    set_idling(1'b0, 0);
    repeat (2) run_random_schedule();
    set_idling(1'b1, 0);
  endtask

  task automatic test_random_schedules(int n_items);
    while (n_sent < n_items) run_random_schedule();
  endtask

  initial begin
    clear_schedule();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_priority_order();
    test_output_backpressure();
    test_steady_stream();
    test_random_schedules(850);
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d input transfers, %0d results checked (%0d completions, %0d idle).",
             n_sent, n_checked, n_completions, n_idle);
    $display("Dropped loads seen: %0d; mismatches: %0d.", n_dropped_loads, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
